@@ rtl/weighted_random_pick_unit_macros.svh @@
// Assertion helpers for the RTL that checks itself.
`ifndef WEIGHTED_RANDOM_PICK_UNIT_MACROS_SVH
`define WEIGHTED_RANDOM_PICK_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define WRP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define WRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wrp_pkg.sv @@
`default_nettype none

package wrp_pkg;

    // Field widths
    localparam int ROLL_W      = 32;
    localparam int WEIGHT_W    = 16;
    localparam int WMAG_W      = 15;
    localparam int IDX_FIELD_W = 4;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 8;

    // Remainder unit step counter
    localparam int                CNT_W    = 5;
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(ROLL_W - 1);

    // Operation codes carried in s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PICK  = 1'b1;

    typedef struct packed {
        logic                        assigned;
        logic signed [WEIGHT_W-1:0]  weight;
    } entry_t;

    // Weight an entry adds to the wheel: zero unless assigned and positive
    function automatic logic [WMAG_W-1:0] contrib(input entry_t e);
        logic [WMAG_W-1:0] w;
        begin
            w = '0;
            if (e.assigned && !e.weight[WEIGHT_W-1] && (e.weight != '0))
            begin
                w = e.weight[WMAG_W-1:0];
            end
            return w;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/wrp_mod.sv @@
`default_nettype none

// Restoring remainder unit: one quotient bit per cycle over the 32-bit roll.
module wrp_mod #(
    parameter int DIV_W = 20
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [wrp_pkg::ROLL_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]           divisor,
    output logic                            done,
    output logic [DIV_W-1:0]                rem
);
    import wrp_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ROLL_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;

    // Trial subtract of divisor from shifted partial remainder
    assign shifted = {rem_reg, quo_reg[ROLL_W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[ROLL_W-2:0], 1'b0};
            rem_next = diff[DIV_W] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

@@ rtl/weighted_random_pick_unit.sv @@
`default_nettype none

// Weighted random pick over a table of up to 16 writable entries (assigned flag plus
// signed 16-bit weight). A write transaction (s_tuser = 0) subtracts the old weight and adds
// the new one, keeping a running total of the positive weights of assigned entries. A
// pick transaction (s_tuser = 1) reduces the 32-bit roll modulo that total in a
// remainder unit that retires one bit per cycle, then walks the table one entry per
// cycle. A pick result enters the output register in the same cycle that the input
// becomes ready again. With a zero total the pick skips the remainder unit and the
// walk and answers found = 0, index 0. The input is not ready while a transaction is
// being worked on; one result may wait in the output register while the next
// transaction is taken. Reset clears the table at once.
module weighted_random_pick_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [3:0] entry_index, [4] entry_assigned, [20:5] entry_weight, [52:21] roll
    input  wire logic [wrp_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] chosen_index
    output logic [wrp_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] found
    output logic                               m_tuser
);
    import wrp_pkg::*;

    `include "weighted_random_pick_unit_macros.svh"

    // Only indices reachable through the 4-bit field are stored
    localparam int TBL_DEPTH = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
    localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int TOT_W     = WMAG_W + $clog2(TBL_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TBL_DEPTH - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WSUB = 3'd1;
    localparam logic [2:0] S_WADD = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    entry_t             tbl_reg [TBL_DEPTH];
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [IDX_W-1:0]   widx_reg, widx_next;
    entry_t             wentry_reg, wentry_next;
    logic [IDX_W-1:0]   walk_reg, walk_next;
    logic [TOT_W-1:0]   rem_reg, rem_next;
    logic               res_found_reg, res_found_next;
    logic [IDX_FIELD_W-1:0] res_idx_reg, res_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [IDX_FIELD_W-1:0] out_idx_reg, out_idx_next;
    logic [ROLL_W-1:0]  roll_reg, roll_next;

    logic               accept;
    logic               in_range;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_entry;
    logic [TOT_W-1:0]   rd_w;
    logic [TOT_W-1:0]   add_op;
    logic [TOT_W-1:0]   add_res;
    logic               hit;
    logic               tbl_we;
    logic               mod_start;
    logic               mod_done;
    logic [TOT_W-1:0]   mod_rem;
    entry_t             in_entry;

    // Input field unpacking
    assign in_entry.assigned = s_tdata[4];
    assign in_entry.weight   = s_tdata[20:5];
    assign in_range          = ({1'b0, s_tdata[3:0]} < 5'(TBL_DEPTH));

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Single table read port, shared by write update and walk
    assign rd_addr  = (state_reg == S_WSUB) ? widx_reg : walk_reg;
    assign rd_entry = tbl_reg[rd_addr];
    assign rd_w     = TOT_W'(contrib(rd_entry));
    assign hit      = (rd_w != '0) && (rem_reg < rd_w);

    // Shared adder for the running total
    assign add_op  = (state_reg == S_WSUB) ? rd_w : TOT_W'(contrib(wentry_reg));
    assign add_res = (state_reg == S_WSUB) ? (total_reg - add_op) : (total_reg + add_op);

    assign tbl_we    = (state_reg == S_WADD);
    assign mod_start = accept && (s_tuser == OP_PICK) && (total_reg != '0);

    wrp_mod #(
        .DIV_W (TOT_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (roll_next),
        .divisor  (total_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        widx_next      = widx_reg;
        wentry_next    = wentry_reg;
        walk_next      = walk_reg;
        rem_next       = rem_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        roll_next      = roll_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == OP_WRITE)
                    begin
                        widx_next   = s_tdata[IDX_W-1:0];
                        wentry_next = in_entry;
                        if (in_range)
                        begin
                            state_next = S_WSUB;
                        end
                    end
                    else
                    begin
                        roll_next      = s_tdata[52:21];
                        res_found_next = 1'b0;
                        res_idx_next   = '0;
                        state_next     = (total_reg != '0) ? S_MOD : S_DONE;
                    end
                end
            end
            S_WSUB:
            begin
                total_next = add_res;
                state_next = S_WADD;
            end
            S_WADD:
            begin
                total_next = add_res;
                state_next = S_IDLE;
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    rem_next   = mod_rem;
                    walk_next  = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (hit || (walk_reg == IDX_LAST))
                begin
                    res_found_next = hit;
                    res_idx_next   = hit ? IDX_FIELD_W'(walk_reg) : '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    rem_next  = rem_reg - rd_w;
                    walk_next = walk_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_idx_next   = res_idx_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (tbl_we)
            begin
                tbl_reg[widx_reg] <= wentry_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        widx_reg      <= widx_next;
        wentry_reg    <= wentry_next;
        walk_reg      <= walk_next;
        rem_reg       <= rem_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        roll_reg      <= roll_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {{(M_TDATA_W - IDX_FIELD_W){1'b0}}, out_idx_reg};

    // Walk remainder stays below the wheel total
    `WRP_ASSERT_IMPL(a_rem_below_total, state_reg == S_WALK, rem_reg < total_reg,
        "walk remainder not below total")

    // The last table entry always ends the walk with a hit
    `WRP_ASSERT_IMPL(a_walk_hits_last, (state_reg == S_WALK) && (walk_reg == IDX_LAST), hit,
        "walk reached the last entry without a hit")

    // Remainder unit only finishes while the sequencer waits for it
    `WRP_ASSERT_IMPL(a_mod_done_in_mod, mod_done, state_reg == S_MOD,
        "remainder unit finished outside its wait state")

    // A miss always reports index zero
    `WRP_ASSERT_NEXT(a_miss_index_zero, (state_reg == S_DONE) && !res_found_reg,
        (res_idx_reg == '0), "miss carries nonzero index")

endmodule

`default_nettype wire

@@ verif/weighted_random_pick_unit_checker.sv @@
`default_nettype none

// Watches both stream channels, keeps a shadow copy of the weight table and
// checks every pick result against the oldest outstanding prediction.
module weighted_random_pick_unit_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    // [3:0] entry_index, [4] entry_assigned, [20:5] entry_weight, [52:21] roll
    input  wire logic [wrp_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  wire logic                          s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] chosen_index
    input  wire logic [wrp_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] found
    input  wire logic                          m_tuser,
    output int                                 mismatches,
    output int                                 pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int TOTAL_W     = 20;

    typedef struct packed {
        logic       found;
        logic [3:0] index;
    } pick_result_t;

    wrp_pkg::entry_t       wheel_table [TABLE_DEPTH];
    logic [TOTAL_W-1:0]    wheel_total;
    pick_result_t          expected_picks[$];
    int                    mismatch_cnt;

    // Weight an entry puts on the wheel; ineligible entries count as zero
    function automatic logic [15:0] slot_weight(input wrp_pkg::entry_t e);
        if (e.assigned && ($signed(e.weight) > 0))
            return e.weight;
        return 16'd0;
    endfunction

    // Roulette walk: roll mod total, then first eligible slot that covers it
    function automatic pick_result_t spin_wheel(input logic [31:0] roll);
        pick_result_t r;
        logic [31:0]  remainder;
        logic [15:0]  w;
        logic         hit;
        r   = '0;
        hit = 1'b0;
        if (wheel_total != '0)
        begin
            remainder = roll % {12'd0, wheel_total};
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                w = slot_weight(wheel_table[i]);
                if (!hit && (w != 16'd0))
                begin
                    if (remainder < {16'd0, w})
                    begin
                        hit     = 1'b1;
                        r.found = 1'b1;
                        r.index = 4'(i);
                    end
                    else
                    begin
                        remainder = remainder - {16'd0, w};
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pick_result_t    exp_r;
        wrp_pkg::entry_t new_entry;
        logic [3:0]      slot;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                wheel_table[i] = '0;
            wheel_total = '0;
            expected_picks.delete();
            mismatch_cnt = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            // Result side first: a result at this edge belongs to an older pick
            if (m_tvalid && m_tready)
            begin
                if (expected_picks.size() == 0)
                begin
                    $display("%0t: unexpected result found=%0b index=%0d",
                             $time, m_tuser, m_tdata[3:0]);
                    mismatch_cnt++;
                end
                else
                begin
                    exp_r = expected_picks.pop_front();
                    if (m_tuser !== exp_r.found)
                    begin
                        $display("%0t: found mismatch, expected %0b actual %0b",
                                 $time, exp_r.found, m_tuser);
                        mismatch_cnt++;
                    end
                    if (m_tdata[3:0] !== exp_r.index)
                    begin
                        $display("%0t: chosen_index mismatch, expected %0d actual %0d",
                                 $time, exp_r.index, m_tdata[3:0]);
                        mismatch_cnt++;
                    end
                end
            end

            // Input side: update the shadow table or predict a pick
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == wrp_pkg::OP_WRITE)
                begin
                    slot               = s_tdata[3:0];
                    new_entry.assigned = s_tdata[4];
                    new_entry.weight   = s_tdata[20:5];
                    wheel_total = wheel_total - TOTAL_W'(slot_weight(wheel_table[slot]));
                    wheel_table[slot] = new_entry;
                    wheel_total = wheel_total + TOTAL_W'(slot_weight(new_entry));
                end
                else
                begin
                    expected_picks.insert(expected_picks.size(),
                                          spin_wheel(s_tdata[52:21]));
                end
            end

            mismatches <= mismatch_cnt;
            pending    <= expected_picks.size();
        end
    end

endmodule

`default_nettype wire

@@ verif/weighted_random_pick_unit_tb.sv @@
`default_nettype none

module weighted_random_pick_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [wrp_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [wrp_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;

    int mismatches;
    int pending;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int quiet_cycles  = 0;
    int items_sent;

    weighted_random_pick_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    weighted_random_pick_unit_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    // Result side backpressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Watchdog: too long without any transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One input transaction, with an optional idle gap in front of it
    task automatic send_item(input logic op, input logic [3:0] idx, input logic assigned,
                             input logic [15:0] weight, input logic [31:0] roll);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, roll, weight, assigned, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_entry(input logic [3:0] idx, input logic assigned,
                               input logic [15:0] weight);
        send_item(wrp_pkg::OP_WRITE, idx, assigned, weight, $urandom);
    endtask

    task automatic pick_entry(input logic [31:0] roll);
        send_item(wrp_pkg::OP_PICK, 4'($urandom), 1'($urandom), 16'($urandom), roll);
    endtask

    // Weight mix: mostly small, some full range, some non-positive
    function automatic logic [15:0] random_weight();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return 16'($urandom_range(1, 64));
        else if (sel < 70)
            return 16'($urandom);
        else if (sel < 85)
            return 16'($urandom_range(1, 32767));
        else if (sel < 92)
            return 16'd0;
        return 16'($urandom_range(32768, 65535));
    endfunction

    function automatic logic [31:0] random_roll();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return $urandom;
        else if (sel < 85)
            return 32'($urandom_range(0, 600000));
        else if (sel < 93)
            return 32'd0;
        return 32'hFFFF_FFFF;
    endfunction

    initial
    begin
        int phase;
        items_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty wheel
        pick_entry(32'd0);
        pick_entry(32'hFFFF_FFFF);
        // Extreme weights and ineligible entries
        write_entry(4'd0, 1'b1, 16'sd32767);
        write_entry(4'd15, 1'b1, 16'sd1);
        write_entry(4'd7, 1'b0, 16'sd1000);
        write_entry(4'd3, 1'b1, 16'h8000);
        write_entry(4'd5, 1'b1, 16'hFFFF);
        // Total 32768: both edges of the first slot, wrap of the full roll
        pick_entry(32'd0);
        pick_entry(32'd32767);
        pick_entry(32'd32766);
        pick_entry(32'hFFFF_FFFF);
        // Zero weight and unassign back to an empty wheel
        write_entry(4'd15, 1'b1, 16'sd0);
        write_entry(4'd0, 1'b0, 16'sd32767);
        pick_entry(32'd12345);
        // Largest possible total
        for (int i = 0; i < 16; i++)
            write_entry(4'(i), 1'b1, 16'sd32767);
        pick_entry(32'hFFFF_FFFF);
        pick_entry(32'd524271);

        // Random part, four idling phases
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            phase = (items_sent * 4) / RANDOM_ITEMS;
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 31; sink_stall_pct = 31; end
            endcase

            if ($urandom_range(99) < 3)
            begin
                // Drain the wheel so picks see an empty table again
                for (int i = 0; i < 16; i++)
                    write_entry(4'(i), 1'($urandom_range(1)),
                                16'($urandom_range(32768, 65536) & 16'hFFFF));
            end
            else if ($urandom_range(99) < 45)
                write_entry(4'($urandom), ($urandom_range(99) < 80), random_weight());
            else
                pick_entry(random_roll());
        end
        s_tvalid <= 1'b0;
        // Let the checker count the last accepted transaction
        @(posedge clk);

        // Drain outstanding results, then watch for strays
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/wrp_pkg.sv
rtl/wrp_mod.sv
rtl/weighted_random_pick_unit.sv
verif/weighted_random_pick_unit_checker.sv
verif/weighted_random_pick_unit_tb.sv
